/* hw/rtl/lapsh_pkg.sv */
// ----------------------------------------------------------------------------
// lapsh_pkg: shared types and constants of the 3x3 RGB sharpening filter
// Widths, register map, pipeline flag and result queue entry types.
// ----------------------------------------------------------------------------
package lapsh_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned MinSize   = 3;

  localparam int unsigned ColW  = 10;
  localparam int unsigned RowW  = 12;
  localparam int unsigned CfgWW = 11;
  localparam int unsigned CfgHW = 13;
  localparam int unsigned WgtRW = 18;
  localparam int unsigned WgtW  = 6;
  localparam int unsigned ChW   = 8;
  localparam int unsigned PixW  = 24;
  localparam int unsigned ProdW = 15;
  localparam int unsigned SumW  = 19;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = FifoPtrW + 1;

  localparam logic [CfgWW-1:0] WidthReset   = CfgWW'(512);
  localparam logic [CfgHW-1:0] HeightReset  = CfgHW'(512);
  localparam logic [WgtRW-1:0] WgtTopReset  = WgtRW'(4032);
  localparam logic [WgtRW-1:0] WgtMidReset  = WgtRW'(258367);
  localparam logic [WgtRW-1:0] WgtBotReset  = WgtRW'(4032);

  typedef enum logic [2:0] {
    RegImageWidth    = 3'd0,
    RegImageHeight   = 3'd1,
    RegWeightsTop    = 3'd2,
    RegWeightsMiddle = 3'd3,
    RegWeightsBottom = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic above;
    logic left;
    logic inner;
    logic right_edge;
    logic bottom;
  } pos_flags_t;

  typedef struct packed {
    logic [2:0]      mask;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic [PixW-1:0] pix0;
    logic [PixW-1:0] pix1;
    logic [PixW-1:0] pix2;
  } run_t;

  function automatic logic signed [WgtW-1:0] weight_at(input logic [WgtRW-1:0] wrow,
                                                      input logic [1:0] k);
    weight_at = $signed(wrow[WgtW*k +: WgtW]);
  endfunction

endpackage

/* hw/rtl/laplacian_sharpen_3x3_rgb.sv */
// A pixel passes s1, s2, s3, the result queue and the output register. Throughput:
// one pixel per clock while stall_o is low; the output port moves one word per
// clock while out_stall_i is low, so bottom-row pixels (up to three words) stall
// the input once the 8-entry result queue fills. Reset clears counters, window,
// queue and registers; the line buffers hold no reset and need no clearing pass.
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_rgb: 3x3 sharpening filter over an RGB raster stream
// Two line buffer RAMs feed a 3x3 window; a multiply stage and a sum/clamp stage
// fill a result-run queue that drains one word per clock while out_stall_i is low.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_rgb (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lapsh_pkg::AddrW-1:0]  paddr,
  input  logic [lapsh_pkg::DataW-1:0]  pwdata,
  output logic [lapsh_pkg::DataW-1:0]  prdata,
  output logic                         pready,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic [lapsh_pkg::ChW-1:0]    blue_i,
  input  logic [lapsh_pkg::ChW-1:0]    green_i,
  input  logic [lapsh_pkg::ChW-1:0]    red_i,
  input  logic                         frame_start_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lapsh_pkg::ChW-1:0]    out_blue_o,
  output logic [lapsh_pkg::ChW-1:0]    out_green_o,
  output logic [lapsh_pkg::ChW-1:0]    out_red_o,
  output logic [lapsh_pkg::RowW-1:0]   out_row_o,
  output logic [lapsh_pkg::ColW-1:0]   out_col_o,
  output logic                         last_of_run_o
);
  import lapsh_pkg::*;

  // configuration
  logic [CfgWW-1:0] cfg_width_q;
  logic [CfgHW-1:0] cfg_height_q;
  logic [WgtRW-1:0] wgt_q [3];
  logic [CfgWW-1:0] w_lim_q;
  logic [CfgHW-1:0] h_lim_q;
  reg_idx_e         reg_idx;
  logic             cfg_wr;

  // stage 0
  logic             accept;
  logic [ColW-1:0]  col_q, c_base, c_cur;
  logic [RowW-1:0]  row_q, r_base, r_cur;
  logic             wrap_c, col_end, row_wrap, byp_d;
  logic [CfgHW-1:0] r_sel, r_inc, r_nxt;
  logic [CfgWW-1:0] c_nxt;
  pos_flags_t       flags_d;

  // stage 1
  logic             s1_valid_q;
  logic [ColW-1:0]  s1_col_q;
  logic [RowW-1:0]  s1_row_q;
  pos_flags_t       s1_flags_q;
  logic [PixW-1:0]  s1_px_q;
  logic [PixW-1:0]  ram_up_q, ram_lo_q;
  logic             byp_q;
  logic [PixW-1:0]  byp_up_q, byp_lo_q;
  logic [PixW-1:0]  s1_up, s1_mid;
  logic [PixW-1:0]  upper_mem [MaxWidth];
  logic [PixW-1:0]  lower_mem [MaxWidth];
  logic [PixW-1:0]  win_q [3][3];

  // stage 2
  logic             s2_valid_q;
  logic [ColW-1:0]  s2_col_q;
  logic [RowW-1:0]  s2_row_q;
  pos_flags_t       s2_flags_q;
  logic signed [ProdW-1:0] prod [3][3][3];

  // stage 3
  logic             s3_valid_q;
  logic [ColW-1:0]  s3_col_q;
  logic [RowW-1:0]  s3_row_q;
  pos_flags_t       s3_flags_q;
  logic signed [ProdW-1:0] s3_prod_q [3][3][3];
  logic [PixW-1:0]  s3_center_q, s3_right_q, s3_px_q;
  logic signed [SumW-1:0] row_sum [3][3];
  logic signed [SumW-1:0] ch_sum [3];
  logic [PixW-1:0]  sharp;
  run_t             push_run;
  logic             push;

  // result queue and output
  run_t                fifo_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q;
  logic [FifoCntW:0]   credit;
  logic [2:0]          done_q, rem, pick;
  run_t                head;
  logic                load, pop, last;
  logic [PixW-1:0]     sel_pix;
  logic [RowW-1:0]     sel_row;
  logic [ColW-1:0]     sel_col;
  logic                out_valid_q, out_last_q;
  logic [PixW-1:0]     out_pix_q;
  logic [RowW-1:0]     out_row_q;
  logic [ColW-1:0]     out_col_q;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      RegImageWidth:    prdata = DataW'(cfg_width_q);
      RegImageHeight:   prdata = DataW'(cfg_height_q);
      RegWeightsTop:    prdata = DataW'(wgt_q[0]);
      RegWeightsMiddle: prdata = DataW'(wgt_q[1]);
      RegWeightsBottom: prdata = DataW'(wgt_q[2]);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WidthReset;
      cfg_height_q <= HeightReset;
      wgt_q[0]     <= WgtTopReset;
      wgt_q[1]     <= WgtMidReset;
      wgt_q[2]     <= WgtBotReset;
      w_lim_q      <= WidthReset;
      h_lim_q      <= HeightReset;
    end else begin
      if (cfg_wr) begin
        unique case (reg_idx)
          RegImageWidth:    cfg_width_q  <= pwdata[CfgWW-1:0];
          RegImageHeight:   cfg_height_q <= pwdata[CfgHW-1:0];
          RegWeightsTop:    wgt_q[0]     <= pwdata[WgtRW-1:0];
          RegWeightsMiddle: wgt_q[1]     <= pwdata[WgtRW-1:0];
          RegWeightsBottom: wgt_q[2]     <= pwdata[WgtRW-1:0];
          default: ;
        endcase
      end
      if (cfg_width_q < CfgWW'(MinSize)) begin
        w_lim_q <= CfgWW'(MinSize);
      end else if (cfg_width_q > CfgWW'(MaxWidth)) begin
        w_lim_q <= CfgWW'(MaxWidth);
      end else begin
        w_lim_q <= cfg_width_q;
      end
      if (cfg_height_q < CfgHW'(MinSize)) begin
        h_lim_q <= CfgHW'(MinSize);
      end else if (cfg_height_q > CfgHW'(MaxHeight)) begin
        h_lim_q <= CfgHW'(MaxHeight);
      end else begin
        h_lim_q <= cfg_height_q;
      end
    end
  end

  // ---------------------------------------------------------------- stage 0
  assign credit  = (FifoCntW+1)'(cnt_q) + (FifoCntW+1)'(s1_valid_q)
                 + (FifoCntW+1)'(s2_valid_q) + (FifoCntW+1)'(s3_valid_q);
  assign stall_o = credit >= (FifoCntW+1)'(FifoDepth);
  assign accept  = valid_i && !stall_o;

  always_comb begin
    c_base   = frame_start_i ? '0 : col_q;
    r_base   = frame_start_i ? '0 : row_q;
    wrap_c   = {1'b0, c_base} >= w_lim_q;
    r_inc    = {1'b0, r_base} + CfgHW'(1);
    r_sel    = wrap_c ? r_inc : {1'b0, r_base};
    r_cur    = (r_sel >= h_lim_q) ? '0 : r_sel[RowW-1:0];
    c_cur    = wrap_c ? '0 : c_base;
    c_nxt    = {1'b0, c_cur} + CfgWW'(1);
    r_nxt    = {1'b0, r_cur} + CfgHW'(1);
    col_end  = c_nxt >= w_lim_q;
    row_wrap = r_nxt >= h_lim_q;
    flags_d.above      = r_cur != '0;
    flags_d.left       = c_cur != '0;
    flags_d.inner      = (r_cur >= RowW'(2)) && (c_cur >= ColW'(2));
    flags_d.right_edge = col_end;
    flags_d.bottom     = r_nxt == h_lim_q;
    byp_d    = s1_valid_q && (s1_col_q == c_cur);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      if (accept) begin
        col_q <= col_end ? '0 : c_nxt[ColW-1:0];
        row_q <= col_end ? (row_wrap ? '0 : r_nxt[RowW-1:0]) : r_cur;
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  assign s1_up  = byp_q ? byp_up_q : ram_up_q;
  assign s1_mid = byp_q ? byp_lo_q : ram_lo_q;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      upper_mem[s1_col_q] <= s1_mid;
      lower_mem[s1_col_q] <= s1_px_q;
    end
    if (accept) begin
      ram_up_q <= upper_mem[c_cur];
      ram_lo_q <= lower_mem[c_cur];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q   <= c_cur;
      s1_row_q   <= r_cur;
      s1_flags_q <= flags_d;
      s1_px_q    <= {red_i, green_i, blue_i};
      byp_q      <= byp_d;
      byp_up_q   <= s1_mid;
      byp_lo_q   <= s1_px_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          win_q[a][b] <= '0;
        end
      end
    end else if (s1_valid_q) begin
      for (int a = 0; a < 3; a++) begin
        win_q[a][0] <= win_q[a][1];
        win_q[a][1] <= win_q[a][2];
      end
      win_q[0][2] <= s1_up;
      win_q[1][2] <= s1_mid;
      win_q[2][2] <= s1_px_q;
    end
  end

  // ---------------------------------------------------------------- stage 2
  always_ff @(posedge clk_i) begin
    s2_col_q   <= s1_col_q;
    s2_row_q   <= s1_row_q;
    s2_flags_q <= s1_flags_q;
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          prod[ch][a][b] = ProdW'(weight_at(wgt_q[a], 2'(b))
                                  * $signed({1'b0, win_q[a][b][ChW*ch +: ChW]}));
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 3
  always_ff @(posedge clk_i) begin
    s3_col_q    <= s2_col_q;
    s3_row_q    <= s2_row_q;
    s3_flags_q  <= s2_flags_q;
    s3_prod_q   <= prod;
    s3_center_q <= win_q[1][1];
    s3_right_q  <= win_q[1][2];
    s3_px_q     <= win_q[2][2];
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int a = 0; a < 3; a++) begin
        row_sum[ch][a] = SumW'(s3_prod_q[ch][a][0]) + SumW'(s3_prod_q[ch][a][1])
                       + SumW'(s3_prod_q[ch][a][2]);
      end
      ch_sum[ch] = $signed(SumW'(s3_center_q[ChW*ch +: ChW])) + row_sum[ch][0]
                 + row_sum[ch][1] + row_sum[ch][2];
      if (ch_sum[ch] < 0) begin
        sharp[ChW*ch +: ChW] = '0;
      end else if (ch_sum[ch] > SumW'(255)) begin
        sharp[ChW*ch +: ChW] = '1;
      end else begin
        sharp[ChW*ch +: ChW] = ch_sum[ch][ChW-1:0];
      end
    end
    push_run.mask = {s3_flags_q.bottom, s3_flags_q.above && s3_flags_q.right_edge,
                     s3_flags_q.above && s3_flags_q.left};
    push_run.row  = s3_row_q;
    push_run.col  = s3_col_q;
    push_run.pix0 = s3_flags_q.inner ? sharp : s3_center_q;
    push_run.pix1 = s3_right_q;
    push_run.pix2 = s3_px_q;
    push = s3_valid_q && (push_run.mask != '0);
  end

  // ---------------------------------------------------------------- queue
  assign head = fifo_q[rd_ptr_q];
  assign rem  = head.mask & ~done_q;
  assign load = (cnt_q != '0) && (!out_valid_q || !out_stall_i);

  always_comb begin
    priority if (rem[0]) begin
      pick    = 3'b001;
      sel_pix = head.pix0;
      sel_row = head.row - RowW'(1);
      sel_col = head.col - ColW'(1);
    end else if (rem[1]) begin
      pick    = 3'b010;
      sel_pix = head.pix1;
      sel_row = head.row - RowW'(1);
      sel_col = head.col;
    end else begin
      pick    = 3'b100;
      sel_pix = head.pix2;
      sel_row = head.row;
      sel_col = head.col;
    end
    last = (rem & ~pick) == '0;
    pop  = load && last;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_run;
    end
    if (load) begin
      out_pix_q  <= sel_pix;
      out_row_q  <= sel_row;
      out_col_q  <= sel_col;
      out_last_q <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
        done_q   <= '0;
      end else if (load) begin
        done_q <= done_q | pick;
      end
      cnt_q <= cnt_q + FifoCntW'(push) - FifoCntW'(pop);
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_blue_o    = out_pix_q[ChW-1:0];
  assign out_green_o   = out_pix_q[2*ChW-1:ChW];
  assign out_red_o     = out_pix_q[3*ChW-1:2*ChW];
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign last_of_run_o = out_last_q;

endmodule

/* hw/rtl/lapsh_checker.sv */
// ----------------------------------------------------------------------------
// lapsh_checker: port-level checks of the sharpening filter output channel
// Watches output words and runs of words caused by one pixel.
// ----------------------------------------------------------------------------
module lapsh_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [lapsh_pkg::ChW-1:0]  out_blue_o,
  input logic [lapsh_pkg::ChW-1:0]  out_green_o,
  input logic [lapsh_pkg::ChW-1:0]  out_red_o,
  input logic [lapsh_pkg::RowW-1:0] out_row_o,
  input logic [lapsh_pkg::ColW-1:0] out_col_o,
  input logic                       last_of_run_o
);
  import lapsh_pkg::*;

  logic run_cont;

  assign run_cont = out_valid_o && !out_stall_i && !last_of_run_o;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_row_o) && $stable(out_col_o)
      && $stable(out_blue_o) && $stable(out_green_o) && $stable(out_red_o)
      && $stable(last_of_run_o))
    else $error("stalled output word changed");

  a_run_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_cont |=> out_valid_o)
    else $error("run of words broken by an idle cycle");

  a_run_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_cont |=> ((out_row_o == $past(out_row_o)) &&
                  (out_col_o == $past(out_col_o) + ColW'(1))) ||
                 ((out_row_o == $past(out_row_o) + RowW'(1)) &&
                  ((out_col_o == $past(out_col_o) + ColW'(1)) ||
                   (out_col_o == $past(out_col_o)))))
    else $error("word position does not follow within a run");

endmodule

bind laplacian_sharpen_3x3_rgb lapsh_checker u_lapsh_checker (.*);
